FILE: sv/ccf_pkg.sv
// Shared types and constants of the condition flag evaluator.
// Depends on nothing; every other file of the block imports it.
package ccf_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;
    localparam int FLAG_W = 5;
    localparam int CNT_W  = 5;

    // Shift count at which the shifted value is fully replaced by fill.
    localparam int SHIFT_LIMIT = 32;

    localparam logic [DATA_W-1:0] TOP_BIT = 32'h8000_0000;

    // Operation kinds.
    localparam logic [OP_W-1:0] OP_FLAGS = 4'd0;
    localparam logic [OP_W-1:0] OP_LOGIC = 4'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
    localparam logic [OP_W-1:0] OP_CMPB  = 4'd4;
    localparam logic [OP_W-1:0] OP_CMPW  = 4'd5;
    localparam logic [OP_W-1:0] OP_ADDX  = 4'd6;
    localparam logic [OP_W-1:0] OP_SUBX  = 4'd7;
    localparam logic [OP_W-1:0] OP_SHL   = 4'd8;
    localparam logic [OP_W-1:0] OP_SHR   = 4'd9;
    localparam logic [OP_W-1:0] OP_SAR   = 4'd10;

    // Bit positions within the flags field.
    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_V_BIT = 1;
    localparam int FLAG_Z_BIT = 2;
    localparam int FLAG_N_BIT = 3;

    // Contents of the decode stage register.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] res;
        logic              cnt_zero;
        logic              cnt_eq_limit;
        logic              cnt_ge_limit;
    } ccf_dec_t;

    // Contents of the execute stage register.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] tmp;
        logic              shift_carry;
    } ccf_exe_t;

endpackage

FILE: sv/ccf_in_if.sv
// Input channel of the condition flag evaluator: valid/ready plus one item.
// Depends on ccf_pkg for the field widths.
interface ccf_in_if;
    import ccf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] source_value;
    logic [DATA_W-1:0] result_value;

    modport source (output valid, output operation, output source_value,
                    output result_value, input ready);
    modport sink   (input valid, input operation, input source_value,
                    input result_value, output ready);
endinterface

FILE: sv/ccf_out_if.sv
// Output channel of the condition flag evaluator: valid/ready plus flags.
// Depends on ccf_pkg for the field width.
interface ccf_out_if;
    import ccf_pkg::*;

    logic              valid;
    logic              ready;
    logic [FLAG_W-1:0] flags;

    modport source (output valid, output flags, input ready);
    modport sink   (input valid, input flags, output ready);
endinterface

FILE: sv/cpu_condition_flag_evaluator.sv
// Registers: each result passes through the decode, execute and flags registers in that order.
// Throughput: one item per cycle while the output is taken; the execute stage's 32-bit adder
// and shifter and the flag stage's 32-bit compares set the stage depth.
// Reset: rst_n clears the stage valid bits asynchronously; the pipeline starts empty.
// Depends on ccf_pkg, ccf_in_if, ccf_out_if and the three stage modules.
module cpu_condition_flag_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    ccf_in_if.sink    operand,
    ccf_out_if.source result
);
    import ccf_pkg::*;

    // Each stage holds one item and its valid bit. A stage takes a new item
    // whenever it is empty or its contents move on in the same cycle, so the
    // chain of ready signals lets every stage advance together while the
    // output is being taken, and a stall at the output freezes the whole
    // pipeline without losing or repeating anything.
    logic     dec_valid;
    logic     dec_ready;
    ccf_dec_t dec;
    logic     exe_valid;
    logic     exe_ready;
    ccf_exe_t exe;

    // Decode: register the item and classify the shift count against the
    // limit of 32, so the next stage sees single-bit decisions.
    ccf_stage_dec u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (operand.valid),
        .up_ready (operand.ready),
        .op       (operand.operation),
        .src      (operand.source_value),
        .res      (operand.result_value),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dec      (dec)
    );

    // Execute: one shared adder recovers the other operand for the add and
    // subtract kinds, and the barrel shifter rebuilds shifted values and
    // picks the last bit shifted out.
    ccf_stage_exe u_exe (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .dec      (dec),
        .dn_valid (exe_valid),
        .dn_ready (exe_ready),
        .exe      (exe)
    );

    // Flags: the magnitude compares and sign tests, written to the output
    // register that drives the result channel.
    ccf_stage_flag u_flag (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (exe_valid),
        .up_ready (exe_ready),
        .exe      (exe),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .flags    (result.flags)
    );

`ifndef SYNTHESIS
    // The input is held off only when all three stages are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> (dec_valid && exe_valid && result.valid))
        else $error("input stalled while the pipeline has room");

    // Shifts never report an overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exe_valid && exe_ready && (exe.op == OP_SHL || exe.op == OP_SHR ||
            exe.op == OP_SAR)) |=> !result.flags[FLAG_V_BIT])
        else $error("overflow flag set by a shift");

    // Outside pass-through, N and Z are never set together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exe_valid && exe_ready && exe.op != OP_FLAGS) |=>
            !(result.flags[FLAG_N_BIT] && result.flags[FLAG_Z_BIT]))
        else $error("N and Z both set");

    // A logical shift by the limit or more always gives a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exe_valid && exe_ready && (exe.op == OP_SHL || exe.op == OP_SHR) &&
            exe.src >= DATA_W'(SHIFT_LIMIT)) |=> result.flags[FLAG_Z_BIT])
        else $error("long logical shift did not give zero");
`endif
endmodule

FILE: sv/ccf_stage_dec.sv
// First pipeline stage: captures the item and classifies the shift count.
// Depends on ccf_pkg.
module ccf_stage_dec (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  logic [ccf_pkg::OP_W-1:0]   op,
    input  logic [ccf_pkg::DATA_W-1:0] src,
    input  logic [ccf_pkg::DATA_W-1:0] res,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output ccf_pkg::ccf_dec_t       dec
);
    import ccf_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ccf_dec_t data_reg;
    ccf_dec_t data_next;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        data_next.op           = op;
        data_next.src          = src;
        data_next.res          = res;
        data_next.cnt_zero     = (src == '0);
        data_next.cnt_eq_limit = (src == DATA_W'(SHIFT_LIMIT));
        data_next.cnt_ge_limit = |src[DATA_W-1:CNT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dec      = data_reg;
endmodule

FILE: sv/ccf_stage_exe.sv
// Second pipeline stage: the shared adder and the barrel shifter.
// Depends on ccf_pkg.
module ccf_stage_exe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  ccf_pkg::ccf_dec_t dec,
    output logic              dn_valid,
    input  logic              dn_ready,
    output ccf_pkg::ccf_exe_t exe
);
    import ccf_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    ccf_exe_t          data_reg;
    ccf_exe_t          data_next;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  left_idx;
    logic [CNT_W-1:0]  right_idx;
    logic [DATA_W-1:0] fill;
    logic              carry_live;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // A count of exactly the limit wraps to zero in the low bits, which
    // makes the last bit out land on bit 0 (left) or bit 31 (right).
    assign cnt        = dec.src[CNT_W-1:0];
    assign left_idx   = CNT_W'(0) - cnt;
    assign right_idx  = cnt - CNT_W'(1);
    assign fill       = {DATA_W{dec.res[DATA_W-1]}};
    assign carry_live = !dec.cnt_zero && (!dec.cnt_ge_limit || dec.cnt_eq_limit);

    always_comb
    begin
        data_next.op          = dec.op;
        data_next.src         = dec.src;
        data_next.res         = dec.res;
        data_next.tmp         = dec.res;
        data_next.shift_carry = 1'b0;
        case (dec.op)
            OP_ADD:
                data_next.tmp = dec.res - dec.src;
            OP_SUB, OP_CMPB, OP_CMPW:
                data_next.tmp = dec.res + dec.src;
            OP_ADDX:
                data_next.tmp = dec.res - dec.src - DATA_W'(1);
            OP_SUBX:
                data_next.tmp = dec.res + dec.src + DATA_W'(1);
            OP_SHL:
            begin
                data_next.tmp         = dec.cnt_ge_limit ? '0 : (dec.res << cnt);
                data_next.shift_carry = carry_live && dec.res[left_idx];
            end
            OP_SHR:
            begin
                data_next.tmp         = dec.cnt_ge_limit ? '0 : (dec.res >> cnt);
                data_next.shift_carry = carry_live && dec.res[right_idx];
            end
            OP_SAR:
            begin
                data_next.tmp         = dec.cnt_ge_limit ? fill
                                      : DATA_W'($signed(dec.res) >>> cnt);
                data_next.shift_carry = carry_live && dec.res[right_idx];
            end
            default:
                data_next.tmp = dec.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign exe      = data_reg;
endmodule

FILE: sv/ccf_stage_flag.sv
// Third pipeline stage: compares and sign tests that form N, Z, V and C,
// held in the output register. Depends on ccf_pkg.
module ccf_stage_flag (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  ccf_pkg::ccf_exe_t          exe,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [ccf_pkg::FLAG_W-1:0] flags
);
    import ccf_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] flags_next;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] add_v;
    logic [DATA_W-1:0] sub_v;
    logic              n_bit;
    logic              z_bit;
    logic              c_bit;
    logic              v_bit;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    assign s     = exe.src;
    assign d     = exe.res;
    assign t     = exe.tmp;
    assign add_v = (s ^ d) & ~(t ^ s);
    assign sub_v = (t ^ d) & (t ^ s);

    always_comb
    begin
        // Z wins over N: a zero value never reports negative.
        z_bit = (d == '0);
        n_bit = d[DATA_W-1];
        c_bit = 1'b0;
        v_bit = 1'b0;
        case (exe.op)
            OP_ADD:
            begin
                c_bit = (d < s);
                v_bit = |(TOP_BIT & add_v);
            end
            OP_SUB:
            begin
                c_bit = (t < s);
                v_bit = |(TOP_BIT & sub_v);
            end
            OP_CMPB:
            begin
                z_bit = (d[7:0] == 8'd0);
                n_bit = d[7];
                c_bit = (t[7:0] < s[7:0]);
                v_bit = sub_v[7];
            end
            OP_CMPW:
            begin
                z_bit = (d[15:0] == 16'd0);
                n_bit = d[15];
                c_bit = (t[15:0] < s[15:0]);
                v_bit = sub_v[15];
            end
            OP_ADDX:
            begin
                c_bit = (d <= s);
                v_bit = |(TOP_BIT & add_v);
            end
            OP_SUBX:
            begin
                c_bit = (t <= s);
                v_bit = |(TOP_BIT & sub_v);
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                z_bit = (t == '0);
                n_bit = t[DATA_W-1];
                c_bit = exe.shift_carry;
            end
            default:
            begin
                c_bit = 1'b0;
            end
        endcase

        flags_next             = '0;
        flags_next[FLAG_C_BIT] = c_bit;
        flags_next[FLAG_V_BIT] = v_bit;
        flags_next[FLAG_Z_BIT] = z_bit;
        flags_next[FLAG_N_BIT] = n_bit && !z_bit;
        if (exe.op == OP_FLAGS)
            flags_next = d[FLAG_W-1:0];
        else if (exe.op > OP_SAR)
            flags_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            flags_reg <= flags_next;
    end

    assign dn_valid = valid_reg;
    assign flags    = flags_reg;
endmodule
